FILE: sv/polar_scan_to_cartesian_core_macros.svh
// Assertion macros shared by the polar scan converter RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef POLAR_SCAN_TO_CARTESIAN_CORE_MACROS_SVH
`define POLAR_SCAN_TO_CARTESIAN_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSTC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pstc check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pstc check failed");

`endif

FILE: sv/pstc_pkg.sv
// Shared types, widths and constants of the polar scan converter.
// No dependencies; imported by every other file of the block but the macro header.
package pstc_pkg;

    localparam int CORDIC_ITERS_DEF = 16;
    localparam int MAX_ITERS        = 32;

    localparam int FIELDS_W   = 4;
    localparam int DIST_W     = 16;
    localparam int ANGLE_W    = 17;
    localparam int COORD_W    = 17;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_FIELDS = 1'b1;

    localparam logic [DIST_W-1:0]   MAX_DISTANCE_RST    = 16'd10000;
    localparam logic [FIELDS_W-1:0] EXPECTED_FIELDS_RST = 4'd4;
    localparam logic [CNT_W-1:0]    CNT_MAX             = '1;

    // angle handling
    localparam int TURN_CDEG = 36000;
    localparam int ANG_W     = 16;             // reduced angle, 0..35999
    localparam int THETA_W   = 32;             // binary angle, one turn = 2^32
    localparam int Q2_W      = 15;             // fractional-turn correction
    localparam int Q_SHIFT   = 36;
    // theta = a*THETA_STEP + floor((a*Q_MUL + Q_ADD) >> Q_SHIFT)
    localparam logic [THETA_W-1:0] THETA_STEP = 32'd119304;
    localparam logic [35:0]        Q_MUL      = 36'd44469137440;
    localparam logic [35:0]        Q_ADD      = 36'd34329196760;

    // magnitude handling
    localparam int FRAC_W     = 16;
    localparam int ROUND_HALF = 32768;
    localparam logic [31:0] GAIN_Q32 = 32'd2608131496;
    localparam int X0_W       = 32;
    localparam int XY_W       = 35;
    localparam int Z_W        = 33;
    localparam int RND_W      = XY_W - FRAC_W;
    localparam int OUT_LIMIT  = 65535;

    // atan(2^-i) in binary angle units
    localparam logic [31:0] ATAN_TAB [MAX_ITERS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // one item as it travels down the rotation chain
    typedef struct packed {
        logic                    vld;
        logic                    ok;
        logic                    moved;
        logic [CNT_W-1:0]        cnt;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [Z_W-1:0]   z;
    } t_tok;

endpackage

FILE: sv/pstc_stream_if.sv
// Valid/ready channel interfaces for sample items and point items.
// Depends on pstc_pkg for field widths.
interface pstc_in_if import pstc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [FIELDS_W-1:0]       field_count;
    logic [DIST_W-1:0]         distance;
    logic signed [ANGLE_W-1:0] angle_centideg;

    modport source(output valid, field_count, distance, angle_centideg, input ready);
    modport sink(input valid, field_count, distance, angle_centideg, output ready);
endinterface

interface pstc_out_if import pstc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      point_valid;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic [CNT_W-1:0]          rejected_total;

    modport source(output valid, point_valid, x_coord, y_coord, rejected_total,
                   input ready);
    modport sink(input valid, point_valid, x_coord, y_coord, rejected_total,
                 output ready);
endinterface

FILE: sv/pstc_prep.sv
// Front end: sample check, reject counter, angle to binary angle, gain scaling.
// Depends on pstc_pkg and the assertion macro header.
`include "polar_scan_to_cartesian_core_macros.svh"

module pstc_prep import pstc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic [FIELDS_W-1:0]       i_field_count,
    input  logic [DIST_W-1:0]         i_distance,
    input  logic signed [ANGLE_W-1:0] i_angle,
    input  logic [DIST_W-1:0]         i_max_distance,
    input  logic [FIELDS_W-1:0]       i_expected_fields,
    output t_tok                      o_tok
);

    localparam int QP_W = ANG_W + 36;
    localparam int GP_W = DIST_W + 32;
    localparam logic signed [ANGLE_W:0] TURN_S = (ANGLE_W+1)'(TURN_CDEG);

    // stage 1: check and reduce
    logic                 w_acc, w_ok;
    logic [CNT_W-1:0]     r_inv, n_inv;
    logic signed [ANGLE_W:0] w_a0, w_a1, w_a2, w_a3;
    logic                 r1_vld, r1_ok;
    logic [CNT_W-1:0]     r1_cnt;
    logic [ANG_W-1:0]     r1_a;
    logic [DIST_W-1:0]    r1_d;
    // stage 2: products
    logic [QP_W-1:0]      w_qprod;
    logic [GP_W-1:0]      w_gprod;
    logic                 r2_vld, r2_ok;
    logic [CNT_W-1:0]     r2_cnt;
    logic [ANG_W-1:0]     r2_a;
    logic [Q2_W-1:0]      r2_q2;
    logic [X0_W-1:0]      r2_x0;
    // stage 3: binary angle
    logic [THETA_W-1:0]   w_theta;
    logic                 r3_vld, r3_ok;
    logic [CNT_W-1:0]     r3_cnt;
    logic [THETA_W-1:0]   r3_theta;
    logic [X0_W-1:0]      r3_x0;
    logic                 w_moved;
    logic [THETA_W-1:0]   w_zt;

    assign w_acc = i_vld && i_en;
    assign w_ok  = (i_field_count == i_expected_fields) && (i_distance <= i_max_distance);

    always_comb begin
        n_inv = r_inv;
        if (w_acc && !w_ok && (r_inv != CNT_MAX)) begin
            n_inv = r_inv + 1'b1;
        end
    end

    // two lifts cover the most negative input, one drop the largest
    always_comb begin
        w_a0 = {i_angle[ANGLE_W-1], i_angle};
        w_a1 = w_a0[ANGLE_W] ? w_a0 + TURN_S : w_a0;
        w_a2 = w_a1[ANGLE_W] ? w_a1 + TURN_S : w_a1;
        w_a3 = (w_a2 >= TURN_S) ? w_a2 - TURN_S : w_a2;
    end

    // floor((728a+562)/1125) by exact reciprocal; rounded gain product
    assign w_qprod = QP_W'(r1_a) * QP_W'(Q_MUL) + QP_W'(Q_ADD);
    assign w_gprod = GP_W'(r1_d) * GP_W'(GAIN_Q32) + GP_W'(ROUND_HALF);
    assign w_theta = THETA_W'(r2_a) * THETA_W'(THETA_STEP) + THETA_W'(r2_q2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv  <= '0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r_inv    <= n_inv;
            r1_vld   <= i_vld;
            r1_ok    <= w_ok;
            r1_cnt   <= n_inv;
            r1_a     <= w_a3[ANG_W-1:0];
            r1_d     <= i_distance;
            r2_vld   <= r1_vld;
            r2_ok    <= r1_ok;
            r2_cnt   <= r1_cnt;
            r2_a     <= r1_a;
            r2_q2    <= w_qprod[Q_SHIFT +: Q2_W];
            r2_x0    <= w_gprod[FRAC_W +: X0_W];
            r3_vld   <= r2_vld;
            r3_ok    <= r2_ok;
            r3_cnt   <= r2_cnt;
            r3_theta <= w_theta;
            r3_x0    <= r2_x0;
        end
    end

    // second and third quadrants: rotate by half a turn, negate at the end
    assign w_moved = r3_theta[THETA_W-1] ^ r3_theta[THETA_W-2];
    assign w_zt    = w_moved ? {~r3_theta[THETA_W-1], r3_theta[THETA_W-2:0]} : r3_theta;

    always_comb begin
        o_tok.vld   = r3_vld;
        o_tok.ok    = r3_ok;
        o_tok.moved = w_moved;
        o_tok.cnt   = r3_cnt;
        o_tok.x     = XY_W'(r3_x0);
        o_tok.y     = '0;
        o_tok.z     = {w_zt[THETA_W-1], w_zt};
    end

    `PSTC_ASSERT_NEXT(a_cnt_mono, i_clk, i_rst_n, 1'b1, r_inv >= $past(r_inv))
    `PSTC_ASSERT_NEXT(a_cnt_bump, i_clk, i_rst_n, w_acc && !w_ok && (r_inv != CNT_MAX), r_inv == $past(r_inv) + 1'b1)
    `PSTC_ASSERT_NEXT(a_cnt_hold, i_clk, i_rst_n, !(w_acc && !w_ok), $stable(r_inv))

endmodule

FILE: sv/pstc_cell.sv
// One rotation-mode CORDIC round with a fixed shift, registered.
// Depends on pstc_pkg for the token type and the arctangent table.
module pstc_cell import pstc_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_tok i_tok,
    output t_tok o_tok
);

    localparam logic signed [Z_W-1:0] STEP_ANG = Z_W'(ATAN_TAB[IDX]);

    logic signed [XY_W-1:0] w_dx, w_dy;
    t_tok                   n_tok, r_tok;

    assign w_dx = i_tok.y >>> IDX;
    assign w_dy = i_tok.x >>> IDX;

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.z[Z_W-1]) begin
            n_tok.x = i_tok.x - w_dx;
            n_tok.y = i_tok.y + w_dy;
            n_tok.z = i_tok.z - STEP_ANG;
        end else begin
            n_tok.x = i_tok.x + w_dx;
            n_tok.y = i_tok.y - w_dy;
            n_tok.z = i_tok.z + STEP_ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else if (i_en) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: sv/pstc_post.sv
// Back end: rounding to whole units, sign fix, saturation, output register.
// Depends on pstc_pkg; also produces the chain advance enable.
module pstc_post import pstc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_tok                      i_tok,
    input  logic                      i_out_ready,
    output logic                      o_en,
    output logic                      o_vld,
    output logic                      o_point_valid,
    output logic signed [COORD_W-1:0] o_x,
    output logic signed [COORD_W-1:0] o_y,
    output logic [CNT_W-1:0]          o_cnt
);

    localparam logic signed [RND_W-1:0] LIM = RND_W'(OUT_LIMIT);
    localparam logic signed [XY_W-1:0]  HALF = XY_W'(ROUND_HALF);

    function automatic logic signed [COORD_W-1:0] fix_coord(
        input logic signed [RND_W-1:0] v,
        input logic                    neg,
        input logic                    ok
    );
        logic signed [RND_W-1:0] s;
        s = neg ? -v : v;
        if (s > LIM) begin
            s = LIM;
        end else if (s < -LIM) begin
            s = -LIM;
        end
        if (!ok) begin
            s = '0;
        end
        return s[COORD_W-1:0];
    endfunction

    logic signed [XY_W-1:0]  w_xsum, w_ysum;
    logic                    r_rnd_vld, r_rnd_ok, r_rnd_moved;
    logic [CNT_W-1:0]        r_rnd_cnt;
    logic signed [RND_W-1:0] r_rnd_x, r_rnd_y;
    logic                    r_out_vld, r_out_ok;
    logic signed [COORD_W-1:0] r_out_x, r_out_y;
    logic [CNT_W-1:0]        r_out_cnt;

    assign o_en   = !r_out_vld || i_out_ready;
    assign w_xsum = i_tok.x + HALF;
    assign w_ysum = i_tok.y + HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (o_en) begin
            r_rnd_vld   <= i_tok.vld;
            r_rnd_ok    <= i_tok.ok;
            r_rnd_moved <= i_tok.moved;
            r_rnd_cnt   <= i_tok.cnt;
            r_rnd_x     <= w_xsum[XY_W-1:FRAC_W];
            r_rnd_y     <= w_ysum[XY_W-1:FRAC_W];
            r_out_vld   <= r_rnd_vld;
            r_out_ok    <= r_rnd_ok;
            r_out_x     <= fix_coord(r_rnd_x, r_rnd_moved, r_rnd_ok);
            r_out_y     <= fix_coord(r_rnd_y, r_rnd_moved, r_rnd_ok);
            r_out_cnt   <= r_rnd_cnt;
        end
    end

    assign o_vld         = r_out_vld;
    assign o_point_valid = r_out_ok;
    assign o_x           = r_out_x;
    assign o_y           = r_out_y;
    assign o_cnt         = r_out_cnt;

endmodule

FILE: sv/polar_scan_to_cartesian_core.sv
// Top level of the polar scan converter: config registers, front end,
// chain of CORDIC cells and output stage. Depends on pstc_pkg, the stream
// interfaces, pstc_prep, pstc_cell, pstc_post and the assertion macros.
//
// Usage:
//   i_sample carries one scanner item per handshake (field count, distance,
//   angle in 0.01 degree). o_point returns exactly one item per sample, in
//   order: point_valid, rounded x and y, and the reject count including
//   this sample. Rejected samples give point_valid 0 and a zero point.
//   The config port writes max_distance (index 0) or expected_fields
//   (index 1) on any edge with i_cfg_we high; write only while idle.
// Timing:
//   An accepted item passes three front-end stages, one stage per CORDIC
//   round, rounding and the output register before o_point valid. A new
//   item can be taken every cycle while the receiver is not holding off.
// Reset and stall:
//   Reset empties the pipeline, clears the reject count and restores the
//   register defaults (10000, 4). When the receiver holds off, the whole
//   chain freezes in place and i_sample.ready drops in the same cycle;
//   nothing is lost or repeated.
`include "polar_scan_to_cartesian_core_macros.svh"

module polar_scan_to_cartesian_core import pstc_pkg::*; #(
    parameter int CORDIC_ITERS = CORDIC_ITERS_DEF   // 8..32 rounds
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pstc_in_if.sink               i_sample,
    pstc_out_if.source            o_point,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [DIST_W-1:0]   r_max_distance;
    logic [FIELDS_W-1:0] r_expected_fields;
    logic                w_en;
    t_tok                w_tok [0:CORDIC_ITERS];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_distance    <= MAX_DISTANCE_RST;
            r_expected_fields <= EXPECTED_FIELDS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_DISTANCE:    r_max_distance    <= i_cfg_data;
                CFG_EXPECTED_FIELDS: r_expected_fields <= i_cfg_data[FIELDS_W-1:0];
                default: ;
            endcase
        end
    end

    // the whole chain advances together; ready follows the output stage
    assign i_sample.ready = w_en;

    // sample check, reject count, binary angle and gain-scaled start vector
    pstc_prep u_prep (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_en),
        .i_vld             (i_sample.valid),
        .i_field_count     (i_sample.field_count),
        .i_distance        (i_sample.distance),
        .i_angle           (i_sample.angle_centideg),
        .i_max_distance    (r_max_distance),
        .i_expected_fields (r_expected_fields),
        .o_tok             (w_tok[0])
    );

    // one cell per round, shift and table entry fixed by position
    for (genvar g = 0; g < CORDIC_ITERS; g++) begin : g_cell
        pstc_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // rounding, half-turn sign fix, saturation and the output register
    pstc_post u_post (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tok         (w_tok[CORDIC_ITERS]),
        .i_out_ready   (o_point.ready),
        .o_en          (w_en),
        .o_vld         (o_point.valid),
        .o_point_valid (o_point.point_valid),
        .o_x           (o_point.x_coord),
        .o_y           (o_point.y_coord),
        .o_cnt         (o_point.rejected_total)
    );

    `PSTC_ASSERT_IMPL(a_reject_zero, i_clk, i_rst_n, o_point.valid && !o_point.point_valid, (o_point.x_coord == '0) && (o_point.y_coord == '0))
    `PSTC_ASSERT_IMPL(a_coord_clamp, i_clk, i_rst_n, o_point.valid, (o_point.x_coord != 17'h10000) && (o_point.y_coord != 17'h10000))
    `PSTC_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, !i_sample.ready, o_point.valid && !o_point.ready)

endmodule
